FILE: hdl/rvh_pkg.sv
// rvh_pkg: shared types, constants and helpers for the radius visibility block
// used by rvh_ctrl, rvh_datapath and radius_visibility_with_hysteresis
`timescale 1ns / 1ps
package rvh_pkg;

  localparam int MAX_ACTORS = 32;
  localparam int MAX_LOOT   = 32;
  localparam int MAX_TABLE  = (MAX_ACTORS > MAX_LOOT) ? MAX_ACTORS : MAX_LOOT;
  localparam int IDX_W      = (MAX_TABLE > 1) ? $clog2(MAX_TABLE) : 1;
  localparam int CNT_W      = $clog2(MAX_TABLE + 1);
  localparam int MEM_DEPTH  = 2 ** (IDX_W + 1);

  localparam int ID_W    = 32;
  localparam int COORD_W = 24;
  localparam int RAD_W   = 23;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = SQ_W + 1;
  localparam int RSQ_W   = 2 * RAD_W;
  localparam int ACT_W   = 3;
  localparam int ST_W    = 3;
  localparam int CFG_IDX_W = 2;

  // input word layout
  localparam int IN_ID_LSB     = 0;
  localparam int IN_X_LSB      = IN_ID_LSB + ID_W;
  localparam int IN_Z_LSB      = IN_X_LSB + COORD_W;
  localparam int IN_ACTIVE_BIT = IN_Z_LSB + COORD_W;
  localparam int IN_ENTER_LSB  = IN_ACTIVE_BIT + 1;
  localparam int IN_LEAVE_LSB  = IN_ENTER_LSB + RAD_W;
  localparam int IN_DATA_W     = 128;
  localparam int IN_USER_W     = ACT_W + 1;
  localparam int OUT_DATA_W    = ID_W;
  localparam int OUT_USER_W    = ST_W + 2;

  typedef logic [ACT_W-1:0] act_t;
  typedef logic [ST_W-1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam act_t ACT_CLEAR_WORLD = act_t'(0);
  localparam act_t ACT_ADD         = act_t'(1);
  localparam act_t ACT_CLEAR_PREV  = act_t'(2);
  localparam act_t ACT_ADD_PREV    = act_t'(3);
  localparam act_t ACT_QUERY       = act_t'(4);

  localparam status_t ST_OK         = status_t'(0);
  localparam status_t ST_DUPLICATE  = status_t'(1);
  localparam status_t ST_OOB        = status_t'(2);
  localparam status_t ST_FULL       = status_t'(3);
  localparam status_t ST_UNORDERED  = status_t'(4);
  localparam status_t ST_BAD_RADII  = status_t'(5);
  localparam status_t ST_CENTER_OUT = status_t'(6);

  localparam cfg_idx_t CFG_MIN_X = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_MIN_Z = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_MAX_X = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_MAX_Z = cfg_idx_t'(3);

  localparam logic KIND_ACTOR = 1'b0;
  localparam logic KIND_LOOT  = 1'b1;

  localparam logic signed [COORD_W-1:0] BND_MIN_RST = '0;
  localparam logic signed [COORD_W-1:0] BND_MAX_RST = {1'b0, {(COORD_W-1){1'b1}}};

  typedef enum logic {OUT_STATUS, OUT_PEND} out_sel_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
  } ent_t;

  typedef struct packed {
    logic             kind;
    logic             in_load;
    logic             ent_clr;
    logic             ent_re;
    logic [IDX_W-1:0] ent_raddr;
    logic             ent_we;
    logic             ent_wsel_in;
    logic [IDX_W-1:0] ent_waddr;
    logic             ent_inc;
    logic             prv_clr;
    logic             prv_add;
    logic             prv_re;
    logic [IDX_W-1:0] prv_raddr;
    logic             rad_en;
    logic             sq_en;
    logic             inprev;
    logic             chk_en;
    logic             pend_load;
    logic             pend_clr;
    logic             out_load;
    out_sel_t         out_sel;
    logic             out_last;
    status_t          status;
  } cmd_t;

  typedef struct packed {
    act_t             act;
    logic             kind;
    logic             active;
    logic [CNT_W-1:0] ent_cnt;
    logic [CNT_W-1:0] prv_cnt;
    logic             ent_full;
    logic             prv_full;
    logic             prv_order_bad;
    logic             in_bnd;
    logic             radii_bad;
    logic             ent_eq;
    logic             ent_gt;
    logic             prv_lt;
    logic             prv_eq;
    logic             hit;
    logic             pend_v;
    logic             out_free;
  } sts_t;

  function automatic logic [CNT_W-1:0] cap_of(input logic kind);
    return kind ? CNT_W'(MAX_LOOT) : CNT_W'(MAX_ACTORS);
  endfunction

endpackage

FILE: hdl/rvh_datapath.sv
// rvh_datapath: input and config registers, entity and previous-id memories,
// distance arithmetic, pending hit and output register; depends on rvh_pkg
`timescale 1ns / 1ps
module rvh_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic [rvh_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [rvh_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                             cfg_valid,
  input  logic [rvh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rvh_pkg::COORD_W-1:0]      cfg_data,
  input  rvh_pkg::cmd_t                    cmd,
  output rvh_pkg::sts_t                    sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rvh_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [rvh_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                             out_tlast
);
  import rvh_pkg::*;

  act_t                      act_r;
  logic                      kind_r;
  logic                      active_r;
  logic [ID_W-1:0]           id_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] z_r;
  logic [RAD_W-1:0]          enter_r;
  logic [RAD_W-1:0]          leave_r;

  logic signed [COORD_W-1:0] min_x_r, min_z_r, max_x_r, max_z_r;

  logic [CNT_W-1:0] ent_cnt_r [2];
  logic [CNT_W-1:0] prv_cnt_r [2];
  logic [ID_W-1:0]  prv_last_r [2];

  ent_t            ent_mem [MEM_DEPTH];
  logic [ID_W-1:0] prv_mem [MEM_DEPTH];
  ent_t            ent_q;
  ent_t            ent_wdata;
  logic [ID_W-1:0] prv_q;

  logic signed [DIFF_W-1:0] dx, dz;
  logic [DIFF_W-1:0]        adx, adz;
  logic [SQ_W-1:0]          sqx_r, sqz_r;
  logic [RSQ_W-1:0]         e2_r, l2_r;
  logic                     inprev_r;
  logic                     hit_r;
  logic [DIST_W-1:0]        dist_sum;
  logic [RSQ_W-1:0]         lim;

  logic            pend_v_r;
  logic            pend_kind_r;
  logic [ID_W-1:0] pend_id_r;

  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  out_last_r;

  // input word
  always_ff @(posedge clk) begin
    if (cmd.in_load && in_tvalid) begin
      act_r    <= in_tuser[ACT_W-1:0];
      kind_r   <= in_tuser[ACT_W];
      id_r     <= in_tdata[IN_ID_LSB +: ID_W];
      x_r      <= in_tdata[IN_X_LSB +: COORD_W];
      z_r      <= in_tdata[IN_Z_LSB +: COORD_W];
      active_r <= in_tdata[IN_ACTIVE_BIT];
      enter_r  <= in_tdata[IN_ENTER_LSB +: RAD_W];
      leave_r  <= in_tdata[IN_LEAVE_LSB +: RAD_W];
    end
  end

  // bounds registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= BND_MIN_RST;
      min_z_r <= BND_MIN_RST;
      max_x_r <= BND_MAX_RST;
      max_z_r <= BND_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_X: min_x_r <= cfg_data;
        CFG_MIN_Z: min_z_r <= cfg_data;
        CFG_MAX_X: max_x_r <= cfg_data;
        CFG_MAX_Z: max_z_r <= cfg_data;
      endcase
    end
  end

  // table and list fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_cnt_r[0] <= '0;
      ent_cnt_r[1] <= '0;
      prv_cnt_r[0] <= '0;
      prv_cnt_r[1] <= '0;
    end else begin
      if (cmd.ent_clr) begin
        ent_cnt_r[0] <= '0;
        ent_cnt_r[1] <= '0;
      end else if (cmd.ent_inc) begin
        ent_cnt_r[cmd.kind] <= ent_cnt_r[cmd.kind] + CNT_W'(1);
      end
      if (cmd.prv_clr) begin
        prv_cnt_r[cmd.kind] <= '0;
      end else if (cmd.prv_add) begin
        prv_cnt_r[cmd.kind] <= prv_cnt_r[cmd.kind] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prv_add) begin
      prv_last_r[cmd.kind] <= id_r;
    end
  end

  // memories
  assign ent_wdata = cmd.ent_wsel_in ? ent_t'{id: id_r, x: x_r, z: z_r} : ent_q;

  always_ff @(posedge clk) begin
    if (cmd.ent_we) begin
      ent_mem[{cmd.kind, cmd.ent_waddr}] <= ent_wdata;
    end
    if (cmd.ent_re) begin
      ent_q <= ent_mem[{cmd.kind, cmd.ent_raddr}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prv_add) begin
      prv_mem[{cmd.kind, prv_cnt_r[cmd.kind][IDX_W-1:0]}] <= id_r;
    end
    if (cmd.prv_re) begin
      prv_q <= prv_mem[{cmd.kind, cmd.prv_raddr}];
    end
  end

  // squared distance
  assign dx  = DIFF_W'(ent_q.x) - DIFF_W'(x_r);
  assign dz  = DIFF_W'(ent_q.z) - DIFF_W'(z_r);
  assign adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign adz = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
  assign dist_sum = DIST_W'(sqx_r) + DIST_W'(sqz_r);
  assign lim  = inprev_r ? l2_r : e2_r;

  always_ff @(posedge clk) begin
    if (cmd.rad_en) begin
      e2_r <= enter_r * enter_r;
      l2_r <= leave_r * leave_r;
    end
    if (cmd.sq_en) begin
      sqx_r    <= adx * adx;
      sqz_r    <= adz * adz;
      inprev_r <= cmd.inprev;
    end
    if (cmd.chk_en) begin
      hit_r <= (dist_sum <= DIST_W'(lim));
    end
  end

  // one hit held back so the last one can be flagged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.pend_load) begin
      pend_v_r <= 1'b1;
    end else if (cmd.pend_clr) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend_kind_r <= cmd.kind;
      pend_id_r   <= ent_q.id;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        OUT_STATUS: begin
          out_data_r <= '0;
          out_user_r <= {1'b0, 1'b0, cmd.status};
          out_last_r <= 1'b1;
        end
        OUT_PEND: begin
          out_data_r <= pend_id_r;
          out_user_r <= {pend_kind_r, 1'b1, ST_OK};
          out_last_r <= cmd.out_last;
        end
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // status toward the controller
  always_comb begin
    sts.act           = act_r;
    sts.kind          = kind_r;
    sts.active        = active_r;
    sts.ent_cnt       = ent_cnt_r[cmd.kind];
    sts.prv_cnt       = prv_cnt_r[cmd.kind];
    sts.ent_full      = ent_cnt_r[cmd.kind] >= cap_of(cmd.kind);
    sts.prv_full      = prv_cnt_r[cmd.kind] >= cap_of(cmd.kind);
    sts.prv_order_bad = (prv_cnt_r[cmd.kind] != '0) && (id_r <= prv_last_r[cmd.kind]);
    sts.in_bnd        = (x_r >= min_x_r) && (x_r <= max_x_r) &&
                        (z_r >= min_z_r) && (z_r <= max_z_r);
    sts.radii_bad     = (enter_r == '0) || (leave_r < enter_r);
    sts.ent_eq        = ent_q.id == id_r;
    sts.ent_gt        = ent_q.id > id_r;
    sts.prv_lt        = prv_q < ent_q.id;
    sts.prv_eq        = prv_q == ent_q.id;
    sts.hit           = hit_r;
    sts.pend_v        = pend_v_r;
    sts.out_free      = !out_v_r || out_tready;
  end

endmodule

FILE: hdl/rvh_ctrl.sv
// rvh_ctrl: sequencer for table updates, previous-list updates and queries
// drives rvh_datapath through cmd_t and reads sts_t; depends on rvh_pkg
`timescale 1ns / 1ps
module rvh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  rvh_pkg::sts_t sts,
  output rvh_pkg::cmd_t cmd
);
  import rvh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, A_RD, A_CMP, A_BND, A_SH, A_SW,
    Q_RD, Q_CMP, Q_SUM, Q_HIT, Q_END, S_RES
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             qk_r, qk_nxt;
  status_t          res_r, res_nxt;
  logic             store;
  logic             jv;

  assign store     = (sts.kind == KIND_ACTOR) || sts.active;
  assign jv        = j_r < sts.prv_cnt;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pos_nxt   = pos_r;
    qk_nxt    = qk_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.kind  = (sts.act == ACT_QUERY) ? qk_r : sts.kind;

    unique case (state_r)
      S_IDLE: begin
        cmd.in_load = 1'b1;
        if (in_tvalid) state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (sts.act)
          ACT_CLEAR_WORLD: begin
            cmd.ent_clr = 1'b1;
            res_nxt     = ST_OK;
            state_nxt   = S_RES;
          end
          ACT_ADD: begin
            if (store && sts.ent_full) begin
              res_nxt   = ST_FULL;
              state_nxt = S_RES;
            end else begin
              i_nxt     = '0;
              pos_nxt   = '0;
              state_nxt = A_RD;
            end
          end
          ACT_CLEAR_PREV: begin
            cmd.prv_clr = 1'b1;
            res_nxt     = ST_OK;
            state_nxt   = S_RES;
          end
          ACT_ADD_PREV: begin
            state_nxt = S_RES;
            if (sts.prv_full) begin
              res_nxt = ST_FULL;
            end else if (sts.prv_order_bad) begin
              res_nxt = ST_UNORDERED;
            end else begin
              cmd.prv_add = 1'b1;
              res_nxt     = ST_OK;
            end
          end
          ACT_QUERY: begin
            if (sts.radii_bad) begin
              res_nxt   = ST_BAD_RADII;
              state_nxt = S_RES;
            end else if (!sts.in_bnd) begin
              res_nxt   = ST_CENTER_OUT;
              state_nxt = S_RES;
            end else begin
              cmd.rad_en = 1'b1;
              qk_nxt     = KIND_ACTOR;
              i_nxt      = '0;
              j_nxt      = '0;
              state_nxt  = Q_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      A_RD: begin
        if (i_r == sts.ent_cnt) begin
          state_nxt = A_BND;
        end else begin
          cmd.ent_re    = 1'b1;
          cmd.ent_raddr = i_r[IDX_W-1:0];
          state_nxt     = A_CMP;
        end
      end
      A_CMP: begin
        if (sts.ent_eq) begin
          res_nxt   = ST_DUPLICATE;
          state_nxt = S_RES;
        end else begin
          if (!sts.ent_gt) pos_nxt = pos_r + CNT_W'(1);
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = A_RD;
        end
      end
      A_BND: begin
        if (!sts.in_bnd) begin
          res_nxt   = ST_OOB;
          state_nxt = S_RES;
        end else if (!store) begin
          res_nxt   = ST_OK;
          state_nxt = S_RES;
        end else begin
          i_nxt     = sts.ent_cnt;
          state_nxt = A_SH;
        end
      end
      A_SH: begin
        if (i_r == pos_r) begin
          cmd.ent_we      = 1'b1;
          cmd.ent_wsel_in = 1'b1;
          cmd.ent_waddr   = pos_r[IDX_W-1:0];
          cmd.ent_inc     = 1'b1;
          res_nxt         = ST_OK;
          state_nxt       = S_RES;
        end else begin
          cmd.ent_re    = 1'b1;
          cmd.ent_raddr = IDX_W'(i_r - CNT_W'(1));
          state_nxt     = A_SW;
        end
      end
      A_SW: begin
        cmd.ent_we    = 1'b1;
        cmd.ent_waddr = i_r[IDX_W-1:0];
        i_nxt         = i_r - CNT_W'(1);
        state_nxt     = A_SH;
      end
      Q_RD: begin
        if (i_r == sts.ent_cnt) begin
          if (qk_r == KIND_ACTOR) begin
            qk_nxt = KIND_LOOT;
            i_nxt  = '0;
            j_nxt  = '0;
          end else begin
            state_nxt = Q_END;
          end
        end else begin
          cmd.ent_re    = 1'b1;
          cmd.ent_raddr = i_r[IDX_W-1:0];
          cmd.prv_re    = 1'b1;
          cmd.prv_raddr = j_r[IDX_W-1:0];
          state_nxt     = Q_CMP;
        end
      end
      Q_CMP: begin
        if (jv && sts.prv_lt) begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = Q_RD;
        end else begin
          cmd.sq_en  = 1'b1;
          cmd.inprev = jv && sts.prv_eq;
          state_nxt  = Q_SUM;
        end
      end
      Q_SUM: begin
        cmd.chk_en = 1'b1;
        state_nxt  = Q_HIT;
      end
      Q_HIT: begin
        priority if (!sts.hit) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = Q_RD;
        end else if (!sts.pend_v) begin
          cmd.pend_load = 1'b1;
          i_nxt         = i_r + CNT_W'(1);
          state_nxt     = Q_RD;
        end else if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OUT_PEND;
          cmd.out_last  = 1'b0;
          cmd.pend_load = 1'b1;
          i_nxt         = i_r + CNT_W'(1);
          state_nxt     = Q_RD;
        end else begin
          state_nxt = Q_HIT;
        end
      end
      Q_END: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.pend_v) begin
            cmd.out_sel  = OUT_PEND;
            cmd.out_last = 1'b1;
            cmd.pend_clr = 1'b1;
          end else begin
            cmd.out_sel = OUT_STATUS;
            cmd.status  = ST_OK;
          end
          state_nxt = S_IDLE;
        end
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_STATUS;
          cmd.status   = res_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      pos_r   <= '0;
      qk_r    <= KIND_ACTOR;
      res_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      pos_r   <= pos_nxt;
      qk_r    <= qk_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

FILE: hdl/radius_visibility_with_hysteresis.sv
// radius_visibility_with_hysteresis: top level joining rvh_ctrl and rvh_datapath
// depends on rvh_pkg, rvh_ctrl, rvh_datapath
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata id,x,z,active,enter,leave; tuser action,kind
//   out_    | out | out_tvalid/tready  | tdata id; tuser status,has_entity,kind; tlast
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// one item at a time; clear and previous-list actions go from dispatch straight to the result
// add entity: reads and compares each stored id of its kind, checks bounds, then moves entries up and writes
// query: reads, compares, squares and checks each stored entity, passing over previous ids alongside
// results leave through a single output register; a stall there holds the scan
// synchronous active-low reset empties both tables and both previous lists
`timescale 1ns / 1ps
module radius_visibility_with_hysteresis (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // id[31:0], pos_x[55:32], pos_z[79:56], active[80], enter[103:81], leave[126:104]
  input  logic [rvh_pkg::IN_DATA_W-1:0]    in_tdata,
  // action[2:0], kind[3]
  input  logic [rvh_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_id[31:0]
  output logic [rvh_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[2:0], has_entity[3], out_kind[4]
  output logic [rvh_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rvh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rvh_pkg::COORD_W-1:0]      cfg_data
);
  import rvh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rvh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rvh_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after accept");

  a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[ST_W] |-> out_tlast)
    else $error("result without entity not marked last");

  a_entity_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[ST_W] |-> out_tuser[ST_W-1:0] == ST_OK)
    else $error("entity result with error status");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while held");

endmodule
